>>> rtl/skibs_pkg.sv
// Shared types, codes and defaults for the sorted key index with binary search.
// Used by every module of the block; no dependencies of its own.
package skibs_pkg;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned POS_W = 12;
    localparam int unsigned TABLE_DEPTH_DEF = 4096;

    // Request codes on s_func
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Result codes on m_status
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT_START,
        S_SHIFT,
        S_PLACE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [POS_W-1:0] pos;
    } tbl_entry_t;

    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

>>> rtl/skibs_table_mem.sv
// Table memory holding key/position pairs in ascending key order.
// One write port and one read port with registered read data; uses skibs_pkg.
module skibs_table_mem #(
    parameter int unsigned TABLE_DEPTH = skibs_pkg::TABLE_DEPTH_DEF,
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                   aclk,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output skibs_pkg::tbl_entry_t  rd_data,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  skibs_pkg::tbl_entry_t  wr_data
);
    import skibs_pkg::*;

    tbl_entry_t mem [TABLE_DEPTH];
    tbl_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/skibs_cmp_unit.sv
// Shared 64-bit unsigned key comparator used by every search step.
// Uses skibs_pkg for the result struct.
module skibs_cmp_unit (
    input  logic [skibs_pkg::KEY_W-1:0] key,
    input  logic [skibs_pkg::KEY_W-1:0] probe,
    output skibs_pkg::cmp_res_t         res
);
    import skibs_pkg::*;

    // Unsigned compare equals bytewise big-endian order
    always_comb begin
        res.eq = (key == probe);
        res.gt = (key > probe);
    end

endmodule

>>> rtl/skibs_ctrl.sv
// Sequencer for insert, lookup and clear: binary search, entry shift and result register.
// Drives the table memory and the shared comparator; uses skibs_pkg.
module skibs_ctrl #(
    parameter int unsigned TABLE_DEPTH = skibs_pkg::TABLE_DEPTH_DEF,
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [skibs_pkg::KEY_W-1:0] s_key,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [skibs_pkg::POS_W-1:0] m_position,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  skibs_pkg::tbl_entry_t       rd_data,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output skibs_pkg::tbl_entry_t       wr_data,
    output logic [skibs_pkg::KEY_W-1:0] cmp_key,
    output logic [skibs_pkg::KEY_W-1:0] cmp_probe,
    input  skibs_pkg::cmp_res_t         cmp_res,
    output logic [CW-1:0]               entry_count
);
    import skibs_pkg::*;

    state_t state_reg, state_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic             lookup_reg, lookup_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [AW-1:0]    mid_reg, mid_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [1:0]       res_status_reg, res_status_next;
    logic [POS_W-1:0] res_pos_reg, res_pos_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_status_reg, m_status_next;
    logic [POS_W-1:0] m_pos_reg, m_pos_next;

    logic             accept;
    logic             full;
    logic             range_open;
    logic [CW:0]      mid_sum;
    logic [CW:0]      mid_full;
    logic [AW-1:0]    mid;
    logic             step_right;
    logic             out_free;
    logic [CW+POS_W-1:0] count_ext;
    logic [POS_W-1:0] new_pos;

    assign accept     = s_valid && s_ready;
    assign full       = (count_reg == CW'(TABLE_DEPTH));
    assign range_open = (lo_reg < hi_reg);
    // Lookup keeps an inclusive upper bound of hi-1, so one is taken off the sum before it is halved
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW+1)'(lookup_reg);
    assign mid_full   = mid_sum >> 1;
    assign mid        = mid_full[AW-1:0];
    assign step_right = cmp_res.gt || (!lookup_reg && cmp_res.eq);
    assign out_free   = !m_valid_reg || m_ready;
    assign count_ext  = {{POS_W{1'b0}}, count_reg};
    assign new_pos    = count_ext[POS_W-1:0];

    assign cmp_key   = key_reg;
    assign cmp_probe = rd_data.key;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_func == FUNC_INSERT) begin
                    state_next = full ? S_DONE : S_PROBE;
                end else if (accept && s_func == FUNC_LOOKUP) begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (range_open) begin
                    state_next = S_CMP;
                end else if (lookup_reg) begin
                    state_next = S_DONE;
                end else if (lo_reg < count_reg) begin
                    state_next = S_SHIFT_START;
                end else begin
                    state_next = S_PLACE;
                end
            end
            S_CMP: begin
                if (lookup_reg && cmp_res.eq) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_PROBE;
                end
            end
            S_SHIFT_START: state_next = S_SHIFT;
            S_SHIFT: begin
                if (!(CW'(idx_reg) > lo_reg)) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE: state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs to memory and input channel
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        rd_addr = mid;
        wr_en   = 1'b0;
        wr_addr = AW'(idx_reg + AW'(1));
        wr_data = rd_data;
        case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_PROBE: rd_en = range_open;
            S_SHIFT_START: begin
                rd_en   = 1'b1;
                rd_addr = AW'(count_reg - CW'(1));
            end
            S_SHIFT: begin
                // Move the entry read last cycle up one slot, fetch the next one down
                wr_en   = 1'b1;
                rd_en   = (CW'(idx_reg) > lo_reg);
                rd_addr = AW'(idx_reg - AW'(1));
            end
            S_PLACE: begin
                wr_en        = 1'b1;
                wr_addr      = lo_reg[AW-1:0];
                wr_data.key  = key_reg;
                wr_data.pos  = new_pos;
            end
            default: ;
        endcase
    end

    // Datapath registers
    always_comb begin
        key_next        = key_reg;
        lookup_next     = lookup_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_pos_next      = m_pos_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    key_next    = s_key;
                    lookup_next = (s_func == FUNC_LOOKUP);
                    lo_next     = '0;
                    hi_next     = count_reg;
                    if (s_func == FUNC_INSERT && full) begin
                        res_status_next = ST_FULL;
                        res_pos_next    = '0;
                    end
                    if (s_func == FUNC_CLEAR) begin
                        count_next = '0;
                    end
                end
            end
            S_PROBE: begin
                mid_next = mid;
                if (!range_open && lookup_reg) begin
                    res_status_next = ST_NOT_FOUND;
                    res_pos_next    = '0;
                end
            end
            S_CMP: begin
                if (lookup_reg && cmp_res.eq) begin
                    res_status_next = ST_FOUND;
                    res_pos_next    = rd_data.pos;
                end else if (step_right) begin
                    lo_next = CW'(mid_reg) + CW'(1);
                end else begin
                    hi_next = CW'(mid_reg);
                end
            end
            S_SHIFT_START: idx_next = AW'(count_reg - CW'(1));
            S_SHIFT: begin
                if (CW'(idx_reg) > lo_reg) begin
                    idx_next = AW'(idx_reg - AW'(1));
                end
            end
            S_PLACE: begin
                count_next      = count_reg + CW'(1);
                res_status_next = ST_INSERTED;
                res_pos_next    = new_pos;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_pos_next    = res_pos_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        lookup_reg     <= lookup_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_status_reg   <= m_status_next;
        m_pos_reg      <= m_pos_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_position  = m_pos_reg;
    assign entry_count = count_reg;

endmodule

>>> rtl/sorted_key_index_binary_search.sv
// Top level of the sorted key index: sequencer, shared comparator and table memory.
// Depends on skibs_pkg, skibs_ctrl, skibs_cmp_unit and skibs_table_mem.
//
// Requests enter on s_valid/s_ready with s_func and s_key; results leave on
// m_valid/m_ready with m_status and m_position. Insert and lookup give one
// result each; clear and the unused code give none.
// One request is worked on at a time: s_ready is high only while idle.
// A lookup runs a binary search over the n entries, a memory read and a
// compare per search step. An insert runs the same search, then moves each
// entry above the insert point up one slot, one at a time through the single
// table write port, and then writes the new entry. A full-table insert skips
// the search and the shift. The result register frees the sequencer: a new
// request is taken while an earlier result waits, and the sequencer holds
// only if a second result is ready before the first is taken.
// Reset empties the table (entry count zero) and drops any pending result;
// the table memory itself needs no clearing pass.
module sorted_key_index_binary_search #(
    parameter int unsigned TABLE_DEPTH = skibs_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_func,
    input  logic [skibs_pkg::KEY_W-1:0] s_key,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [skibs_pkg::POS_W-1:0] m_position
);
    import skibs_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    tbl_entry_t       rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    tbl_entry_t       wr_data;
    logic [KEY_W-1:0] cmp_key;
    logic [KEY_W-1:0] cmp_probe;
    cmp_res_t         cmp_res;
    logic [CW-1:0]    entry_count;

    skibs_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_position  (m_position),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .cmp_key     (cmp_key),
        .cmp_probe   (cmp_probe),
        .cmp_res     (cmp_res),
        .entry_count (entry_count)
    );

    skibs_cmp_unit u_cmp (
        .key   (cmp_key),
        .probe (cmp_probe),
        .res   (cmp_res)
    );

    skibs_table_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_busy_after_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_func == FUNC_INSERT || s_func == FUNC_LOOKUP))
        |=> !s_ready)
        else $error("sequencer idle right after insert or lookup request");

    a_miss_zero_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_NOT_FOUND || m_status == ST_FULL))
        |-> (m_position == '0))
        else $error("nonzero position on miss or full result");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !wr_en)
        else $error("table write while idle");

endmodule

>>> tb/sv/testbench.sv
// Self-checking bench for the sorted key index: inserts, lookups and clears over valid/ready.
// Depends on skibs_pkg and sorted_key_index_binary_search; answers come from an in-bench table.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import skibs_pkg::*;

    localparam int DEPTH          = TABLE_DEPTH_DEF;
    localparam int RAND_ITEMS     = 1250;
    localparam int DIR_ROWS       = 24;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 20000;
    localparam int TAIL_CYCLES    = 64;

    // The block ignores this code
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
    } answer_t;

    typedef struct packed {
        logic             typed;
        logic [1:0]       status;
        logic [POS_W-1:0] position;
    } req_note_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic             typed;
        logic [1:0]       status;
        logic [POS_W-1:0] position;
    } dir_row_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [1:0]       s_func = FUNC_INSERT;
    logic [KEY_W-1:0] s_key = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_status;
    logic [POS_W-1:0] m_position;

    // Bench copy of the index
    logic [KEY_W-1:0] key_tbl [DEPTH];
    logic [POS_W-1:0] slot_pos_tbl [DEPTH];
    int               entry_cnt = 0;

    answer_t          pending_answers [$];
    req_note_t        request_notes [$];
    logic [KEY_W-1:0] live_keys [$];
    logic [KEY_W-1:0] extreme_keys [4];
    dir_row_t         dir_rows [DIR_ROWS];

    int err_cnt = 0;
    int stall_cycles = 0;
    bit no_idle = 1'b0;
    bit rx_hold_req = 1'b0;

    sorted_key_index_binary_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_key     (s_key),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_status  (m_status),
        .m_position(m_position)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one request to the bench index and say what answer it gives, if any.
    function automatic void predict_index_op(input logic [1:0] f, input logic [KEY_W-1:0] k,
                                             output bit gives, output answer_t ans);
        int lo;
        int hi;
        int mid;
        bit hit;
        gives = 1'b0;
        ans = '0;
        hit = 1'b0;
        if (f == FUNC_INSERT) begin
            gives = 1'b1;
            if (entry_cnt >= DEPTH) begin
                ans.status = ST_FULL;
            end else begin
                // Upper bound keeps equal keys in insertion order
                lo = 0;
                hi = entry_cnt;
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (key_tbl[mid] <= k) lo = mid + 1;
                    else hi = mid;
                end
                for (int i = entry_cnt; i > lo; i--) begin
                    key_tbl[i] = key_tbl[i-1];
                    slot_pos_tbl[i] = slot_pos_tbl[i-1];
                end
                key_tbl[lo] = k;
                slot_pos_tbl[lo] = POS_W'(entry_cnt);
                ans.status = ST_INSERTED;
                ans.position = POS_W'(entry_cnt);
                entry_cnt++;
            end
        end else if (f == FUNC_LOOKUP) begin
            gives = 1'b1;
            ans.status = ST_NOT_FOUND;
            lo = 0;
            hi = entry_cnt - 1;
            while (!hit && lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (key_tbl[mid] == k) begin
                    hit = 1'b1;
                    ans.status = ST_FOUND;
                    ans.position = slot_pos_tbl[mid];
                end else if (k > key_tbl[mid]) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end else if (f == FUNC_CLEAR) begin
            entry_cnt = 0;
        end
    endfunction

    // Stored key, a neighbor of one, or a random key.
    function automatic logic [KEY_W-1:0] lookup_target();
        int r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (live_keys.size() == 0 || r >= 80) begin
            k = {$urandom, $urandom};
        end else begin
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            if (r >= 50) k = r[0] ? k + 64'd1 : k - 64'd1;
        end
        return k;
    endfunction

    // Offer one request and hold it until accepted; valid stays high on return.
    task automatic send_req(input logic [1:0] f, input logic [KEY_W-1:0] k,
                            input logic typed = 1'b0, input logic [1:0] t_status = ST_INSERTED,
                            input logic [POS_W-1:0] t_position = '0);
        req_note_t note;
        note.typed = typed;
        note.status = t_status;
        note.position = t_position;
        while (!no_idle && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        request_notes.push_back(note);
        s_valid <= 1'b1;
        s_func <= f;
        s_key <= k;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (f == FUNC_INSERT) live_keys.push_back(k);
        else if (f == FUNC_CLEAR) live_keys.delete();
    endtask

    // Stop offering and hold until every answer is back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    // Receiver: random backpressure, plus one long hold-off on request
    initial begin
        int hold_left = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req && hold_left == 0) hold_left = RX_HOLD_CYCLES;
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
                if (hold_left == 0) rx_hold_req = 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 25);
            end
        end
    end

    // Predict on every accepted request, check every accepted answer, watch for a hang
    always @(posedge aclk) begin
        bit        gives;
        answer_t   ans;
        answer_t   want;
        req_note_t note;
        bit        s_fire;
        bit        m_fire;
        if (aresetn) begin
            s_fire = s_valid && s_ready;
            m_fire = m_valid && m_ready;
            if (s_fire) begin
                note = '0;
                if (request_notes.size() != 0) note = request_notes.pop_front();
                predict_index_op(s_func, s_key, gives, ans);
                if (gives) begin
                    want = ans;
                    if (note.typed) begin
                        want.status = note.status;
                        want.position = note.position;
                    end
                    pending_answers.push_back(want);
                end
            end
            if (m_fire) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: unexpected answer, expected none actual status %0d position %0d",
                             $time, m_status, m_position);
                    err_cnt++;
                end else begin
                    want = pending_answers.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, want.status, m_status);
                        err_cnt++;
                    end
                    if (m_position !== want.position) begin
                        $display("%0t: position mismatch, expected %0d actual %0d",
                                 $time, want.position, m_position);
                        err_cnt++;
                    end
                end
            end
            if (s_fire || m_fire) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [KEY_W-1:0] key_pool [8];
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] fill_key;
        logic [1:0]       f;
        int               rand_count;
        int               n;
        int               r;
        bit               paused;

        extreme_keys = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                         64'h7FFF_FFFF_FFFF_FFFF};
        dir_rows = '{
            '{FUNC_LOOKUP, 64'h0,                   1'b1, ST_NOT_FOUND, 12'd0},
            '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NOT_FOUND, 12'd0},
            '{FUNC_INSERT, 64'h5555_5555_5555_5555, 1'b1, ST_INSERTED,  12'd0},
            '{FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_INSERTED,  12'd1},
            '{FUNC_INSERT, 64'h0,                   1'b1, ST_INSERTED,  12'd2},
            '{FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, ST_INSERTED,  12'd3},
            '{FUNC_INSERT, 64'h5555_5555_5555_5555, 1'b1, ST_INSERTED,  12'd4},
            '{FUNC_INSERT, 64'h5555_5555_5555_5555, 1'b1, ST_INSERTED,  12'd5},
            '{FUNC_LOOKUP, 64'h0,                   1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'h5555_5555_5555_5555, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'h8000_0000_0000_0000, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_CLEAR,  64'h0,                   1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'h5555_5555_5555_5555, 1'b1, ST_NOT_FOUND, 12'd0},
            '{FUNC_INSERT, 64'h0102_0304_0506_0708, 1'b1, ST_INSERTED,  12'd0},
            '{FUNC_INSERT, 64'h0807_0605_0403_0201, 1'b1, ST_INSERTED,  12'd1},
            '{FUNC_INSERT, 64'h00FF_00FF_00FF_00FF, 1'b1, ST_INSERTED,  12'd2},
            '{FUNC_LOOKUP, 64'h0807_0605_0403_0201, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'h00FF_00FF_00FF_00FF, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_LOOKUP, 64'h0102_0304_0506_0708, 1'b0, ST_INSERTED,  12'd0},
            '{FUNC_CLEAR,  64'h0,                   1'b0, ST_INSERTED,  12'd0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_req(dir_rows[i].func, dir_rows[i].key, dir_rows[i].typed,
                     dir_rows[i].status, dir_rows[i].position);
        end
        wait_drained();

        // Fill with ascending keys so no entry moves, then force one full-length shift
        send_req(FUNC_CLEAR, {$urandom, $urandom});
        fill_key = {$urandom & 32'h0FFF_FFFF, $urandom} | 64'd1;
        for (int i = 0; i < DEPTH - 2; i++) begin
            fill_key = fill_key + 64'($urandom_range(1, 1 << 20));
            if ($urandom_range(0, 9) == 0) send_req(FUNC_LOOKUP, lookup_target());
            send_req(FUNC_INSERT, fill_key);
        end
        send_req(FUNC_INSERT, 64'h0, 1'b1, ST_INSERTED, POS_W'(DEPTH - 2));
        send_req(FUNC_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_INSERTED, POS_W'(DEPTH - 1));
        send_req(FUNC_INSERT, {$urandom, $urandom}, 1'b1, ST_FULL, 12'd0);
        send_req(FUNC_INSERT, 64'h0, 1'b1, ST_FULL, 12'd0);
        send_req(FUNC_LOOKUP, 64'h0);
        send_req(FUNC_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF);
        send_req(FUNC_LOOKUP, fill_key);
        for (int i = 0; i < 20; i++) send_req(FUNC_LOOKUP, lookup_target());
        send_req(FUNC_CLEAR, 64'h0);
        send_req(FUNC_LOOKUP, fill_key, 1'b1, ST_NOT_FOUND, 12'd0);
        wait_drained();

        // Random sequences; start with the receiver held off so the input stalls
        rx_hold_req = 1'b1;
        rand_count = 0;
        paused = 1'b0;
        while (rand_count < RAND_ITEMS) begin
            no_idle = (rand_count >= 300 && rand_count < 550);
            if (rand_count >= 800 && !paused) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(0, 7) == 0) begin
                // Noise: any code, any key
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    f = 2'($urandom_range(0, 3));
                    send_req(f, {$urandom, $urandom});
                    if (f != FUNC_UNUSED) rand_count++;
                end
            end else begin
                if (live_keys.size() > 150 || $urandom_range(0, 3) != 0) begin
                    send_req(FUNC_CLEAR, {$urandom, $urandom});
                    rand_count++;
                end
                for (int j = 0; j < 8; j++) key_pool[j] = {$urandom, $urandom};
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 40) k = key_pool[$urandom_range(0, 7)];
                    else if (r < 50) k = extreme_keys[$urandom_range(0, 3)];
                    else k = {$urandom, $urandom};
                    send_req(FUNC_INSERT, k);
                    rand_count++;
                    if ($urandom_range(0, 4) == 0) begin
                        send_req(FUNC_LOOKUP, lookup_target());
                        rand_count++;
                    end
                end
                n = $urandom_range(1, 16);
                for (int i = 0; i < n; i++) begin
                    send_req(FUNC_LOOKUP, lookup_target());
                    rand_count++;
                end
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_answers.size() != 0) begin
            $display("%0t: %0d answers never arrived", $time, pending_answers.size());
            err_cnt++;
        end
        if (err_cnt == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

>>> sorted_key_index_binary_search.f
rtl/skibs_pkg.sv
rtl/skibs_table_mem.sv
rtl/skibs_cmp_unit.sv
rtl/skibs_ctrl.sv
rtl/sorted_key_index_binary_search.sv
tb/sv/testbench.sv
